// ===== hw/rtl/fma_pkg.sv =====
// ----------------------------------------------------------------------------
// fma_pkg: shared constants for the filtered magnetic angle unit
// Field widths, register reset value, angle format and the arctangent table.
// ----------------------------------------------------------------------------
package fma_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 9;
   localparam int SHIFT_W  = 4;

   // Filter shift register
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd8;

   // Angle accumulator: degrees in units of 2^-ANG_FRAC
   localparam int ANG_FRAC = 24;
   localparam int ACC_W    = 35;
   localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(180) << ANG_FRAC;
   localparam logic [ACC_W-1:0] FULL_TURN  = ACC_W'(360) << ANG_FRAC;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ANG_FRAC - 1);
   localparam logic [ANGLE_W-1:0] DEG_FULL = 9'd360;

   // atan(2^-i) in degrees, rounded to 2^-24 degree
   localparam int TBL_LEN   = 24;
   localparam int TBL_IDX_W = 5;
   localparam logic [31:0] ATAN_DEG_Q24 [TBL_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

endpackage

// ===== hw/rtl/fma_ifs.sv =====
// ----------------------------------------------------------------------------
// fma channel interfaces
// Valid/ready channels for samples, results and the filter shift register.
// ----------------------------------------------------------------------------

// Raw three-axis sample
interface fma_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fma_pkg::SAMPLE_W-1:0] sample_x;
   logic signed [fma_pkg::SAMPLE_W-1:0] sample_y;
   logic signed [fma_pkg::SAMPLE_W-1:0] sample_z;
   modport source (output valid, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

// Filtered axes and heading
interface fma_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [fma_pkg::ANGLE_W-1:0]  angle_degrees;
   logic signed [fma_pkg::SAMPLE_W-1:0] filtered_x;
   logic signed [fma_pkg::SAMPLE_W-1:0] filtered_y;
   logic signed [fma_pkg::SAMPLE_W-1:0] filtered_z;
   modport source (output valid, angle_degrees, filtered_x, filtered_y, filtered_z,
                   input ready);
   modport sink   (input valid, angle_degrees, filtered_x, filtered_y, filtered_z,
                   output ready);
endinterface

// Filter shift register write
interface fma_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fma_pkg::SHIFT_W-1:0]        filter_shift;
   modport source (output valid, filter_shift, input ready);
   modport sink   (input valid, filter_shift, output ready);
endinterface

// ===== hw/rtl/fma_front.sv =====
// ----------------------------------------------------------------------------
// fma_front: sample intake and low-pass filter
// Holds the filter shift register and the three filter states; each sample
// transfer updates the states and pushes the new values into the queue.
// ----------------------------------------------------------------------------
module fma_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fma_pkg::SAMPLE_W-1:0]   sample_x,
   input  logic signed [fma_pkg::SAMPLE_W-1:0]   sample_y,
   input  logic signed [fma_pkg::SAMPLE_W-1:0]   sample_z,
   // register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [fma_pkg::SHIFT_W-1:0]    csr_shift,
   // queue push: {avg_x, avg_y, integer z}
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output logic [2*(fma_pkg::SAMPLE_W+FRAC_BITS)+fma_pkg::SAMPLE_W-1:0] push_data
);

   localparam int AVG_W = fma_pkg::SAMPLE_W + FRAC_BITS;

   logic [fma_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [fma_pkg::SHIFT_W-1:0] shift_eff;
   logic signed [AVG_W-1:0]     avg_x_ff, avg_x_in;
   logic signed [AVG_W-1:0]     avg_y_ff, avg_y_in;
   logic signed [AVG_W-1:0]     avg_z_ff, avg_z_in;
   logic signed [AVG_W-1:0]     next_x, next_y, next_z;
   logic                        take;

   // One filter step: avg + ((sample << FRAC) - avg) >>> shift
   function automatic logic signed [AVG_W-1:0] smooth(
      input logic signed [AVG_W-1:0]            avg,
      input logic signed [fma_pkg::SAMPLE_W-1:0] sample,
      input logic [fma_pkg::SHIFT_W-1:0]         sh
   );
      logic signed [AVG_W:0] target;
      logic signed [AVG_W:0] diff;
      logic signed [AVG_W:0] step;
      logic signed [AVG_W:0] sum;
      target = {sample[fma_pkg::SAMPLE_W-1], sample, {FRAC_BITS{1'b0}}};
      diff   = target - {avg[AVG_W-1], avg};
      // shift on its own so it stays arithmetic
      step   = diff >>> sh;
      sum    = {avg[AVG_W-1], avg} + step;
      return sum[AVG_W-1:0];
   endfunction

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;

   // Shift values above the range act as the maximum
   assign shift_eff = (shift_ff > fma_pkg::SHIFT_MAX) ? fma_pkg::SHIFT_MAX : shift_ff;

   assign next_x = smooth(avg_x_ff, sample_x, shift_eff);
   assign next_y = smooth(avg_y_ff, sample_y, shift_eff);
   assign next_z = smooth(avg_z_ff, sample_z, shift_eff);

   assign push_data = {next_x, next_y, next_z[AVG_W-1:FRAC_BITS]};

   // Next state
   always_comb begin
      shift_in = csr_valid ? csr_shift : shift_ff;
      avg_x_in = take ? next_x : avg_x_ff;
      avg_y_in = take ? next_y : avg_y_ff;
      avg_z_in = take ? next_z : avg_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= fma_pkg::SHIFT_RESET;
         avg_x_ff <= '0;
         avg_y_ff <= '0;
         avg_z_ff <= '0;
      end else begin
         shift_ff <= shift_in;
         avg_x_ff <= avg_x_in;
         avg_y_ff <= avg_y_in;
         avg_z_ff <= avg_z_in;
      end
   end

endmodule

// ===== hw/rtl/fma_queue.sv =====
// ----------------------------------------------------------------------------
// fma_queue: small register FIFO between intake and angle engine
// Lets the filter take samples while the CORDIC is still busy.
// ----------------------------------------------------------------------------
module fma_queue #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fma_queue: fill count above depth");

   // Pointers meet whenever the queue is empty or full
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("fma_queue: pointers disagree with fill count");

endmodule

// ===== hw/rtl/fma_back.sv =====
// ----------------------------------------------------------------------------
// fma_back: iterative CORDIC heading engine
// Pops filtered states, runs vectoring CORDIC one micro-rotation per cycle,
// rounds the angle to whole degrees and holds the result in an output register.
// ----------------------------------------------------------------------------
module fma_back #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // queue pop: {avg_x, avg_y, integer z}
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  logic [2*(fma_pkg::SAMPLE_W+FRAC_BITS)+fma_pkg::SAMPLE_W-1:0] pop_data,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [fma_pkg::ANGLE_W-1:0]    angle_degrees,
   output logic signed [fma_pkg::SAMPLE_W-1:0]   filtered_x,
   output logic signed [fma_pkg::SAMPLE_W-1:0]   filtered_y,
   output logic signed [fma_pkg::SAMPLE_W-1:0]   filtered_z
);

   localparam int AVG_W = fma_pkg::SAMPLE_W + FRAC_BITS;
   // headroom for negation and CORDIC gain
   localparam int XW    = AVG_W + 3;
   localparam int SW    = fma_pkg::SAMPLE_W;
   localparam int AW    = fma_pkg::ACC_W;
   localparam int IW    = fma_pkg::TBL_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROT   = 3'b010,
      ST_ROUND = 3'b100
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic signed [XW-1:0]    x_ff, x_in;
   logic signed [XW-1:0]    y_ff, y_in;
   logic [AW-1:0]           acc_ff, acc_in;
   logic [IW-1:0]           step_ff, step_in;
   logic                    zero_ff, zero_in;
   logic [SW-1:0]           ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic                    out_valid_ff, out_valid_in;
   logic [fma_pkg::ANGLE_W-1:0] angle_ff, angle_in;
   logic [SW-1:0]           fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;

   logic signed [AVG_W-1:0] ld_x, ld_y;
   logic signed [XW-1:0]    ext_x, ext_y;
   logic signed [XW-1:0]    dx, dy;
   logic [AW-1:0]           atan_step;
   logic [AW-1:0]           acc_wrap, acc_rnd;
   logic [fma_pkg::ANGLE_W-1:0] deg;
   logic                    slot_free;
   logic                    last_step;

   assign ld_x  = pop_data[2*AVG_W+SW-1 -: AVG_W];
   assign ld_y  = pop_data[AVG_W+SW-1 -: AVG_W];
   assign ext_x = {{(XW-AVG_W){ld_x[AVG_W-1]}}, ld_x};
   assign ext_y = {{(XW-AVG_W){ld_y[AVG_W-1]}}, ld_y};

   assign pop_ready = (state_ff == ST_IDLE);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign last_step = (step_ff == IW'(CORDIC_STEPS - 1));

   // Micro-rotation datapath
   assign dx        = y_ff >>> step_ff;
   assign dy        = x_ff >>> step_ff;
   assign atan_step = AW'(fma_pkg::ATAN_DEG_Q24[step_ff]);

   // Wrap into one turn, round half up, full turn reads as zero
   assign acc_wrap = acc_ff[AW-1] ? acc_ff + fma_pkg::FULL_TURN : acc_ff;
   assign acc_rnd  = acc_wrap + fma_pkg::ROUND_HALF;
   assign deg      = acc_rnd[fma_pkg::ANG_FRAC +: fma_pkg::ANGLE_W];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      iz_in        = iz_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      angle_in     = angle_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      fz_in        = fz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               // left half plane is turned by 180 degrees first
               if (ld_x[AVG_W-1]) begin
                  x_in   = -ext_x;
                  y_in   = -ext_y;
                  acc_in = fma_pkg::HALF_TURN;
               end else begin
                  x_in   = ext_x;
                  y_in   = ext_y;
                  acc_in = '0;
               end
               zero_in  = (ld_x == '0) && (ld_y == '0);
               ix_in    = ld_x[AVG_W-1:FRAC_BITS];
               iy_in    = ld_y[AVG_W-1:FRAC_BITS];
               iz_in    = pop_data[SW-1:0];
               step_in  = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (!y_ff[XW-1]) begin
               x_in   = x_ff + dx;
               y_in   = y_ff - dy;
               acc_in = acc_ff + atan_step;
            end else begin
               x_in   = x_ff - dx;
               y_in   = y_ff + dy;
               acc_in = acc_ff - atan_step;
            end
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (zero_ff || deg >= fma_pkg::DEG_FULL) begin
                  angle_in = '0;
               end else begin
                  angle_in = deg;
               end
               fx_in    = ix_ff;
               fy_in    = iy_ff;
               fz_in    = iz_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
      zero_ff  <= zero_in;
      ix_ff    <= ix_in;
      iy_ff    <= iy_in;
      iz_ff    <= iz_in;
      angle_ff <= angle_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      fz_ff    <= fz_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign angle_degrees = angle_ff;
   assign filtered_x    = fx_ff;
   assign filtered_y    = fy_ff;
   assign filtered_z    = fz_ff;

   // Reported heading always within one turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (angle_ff < fma_pkg::DEG_FULL))
      else $error("fma_back: angle out of range");

   // Step counter never runs past the last micro-rotation
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> (step_ff <= IW'(CORDIC_STEPS - 1)))
      else $error("fma_back: CORDIC step past end");

   // A finished rotation lands in the output register
   a_round_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && slot_free) |=> (out_valid_ff && state_ff == ST_IDLE))
      else $error("fma_back: rounded result not delivered");

endmodule

// ===== hw/rtl/filtered_magnetic_angle_unit.sv =====
// ----------------------------------------------------------------------------
// filtered_magnetic_angle_unit: smoothed three-axis field and heading
// Low-pass filters each sample axis and reports the filtered axes together
// with atan2(y, x) in whole degrees.
// ----------------------------------------------------------------------------
// Each sample transfer updates three exponential filters (state Q16.FRAC_BITS,
// step (sample - avg) >>> filter_shift, shift values above 8 act as 8) and
// produces exactly one result. The heading comes from a single iterative
// CORDIC unit that does one micro-rotation per clock: each sample is loaded,
// rotated CORDIC_STEPS times and rounded, and the unit takes no new sample
// until the last one is rounded. A two-entry queue between the filter and
// the CORDIC lets samples be taken while an angle is computed, and the
// output register lets the CORDIC move on while a result waits.
// The filter_shift register resets to 5 and is written through csr_chan.
module filtered_magnetic_angle_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input logic clock,
   input logic reset,
   fma_req_if.sink   req_chan,
   fma_rsp_if.source rsp_chan,
   fma_csr_if.sink   csr_chan
);

   localparam int AVG_W   = fma_pkg::SAMPLE_W + FRAC_BITS;
   localparam int QUEUE_W = 2 * AVG_W + fma_pkg::SAMPLE_W;

   logic               push_valid, push_ready;
   logic [QUEUE_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [QUEUE_W-1:0] pop_data;

   // Intake and filter
   fma_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .sample_x   (req_chan.sample_x),
      .sample_y   (req_chan.sample_y),
      .sample_z   (req_chan.sample_z),
      .csr_valid  (csr_chan.valid),
      .csr_ready  (csr_chan.ready),
      .csr_shift  (csr_chan.filter_shift),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decoupling queue
   fma_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Heading engine
   fma_back #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .angle_degrees (rsp_chan.angle_degrees),
      .filtered_x    (rsp_chan.filtered_x),
      .filtered_y    (rsp_chan.filtered_y),
      .filtered_z    (rsp_chan.filtered_z)
   );

endmodule
